FILE: rtl/core/bitmap_slot_allocator_top_defines.svh
// Assertion macros for the bitmap slot allocator.
// Used by bitmap_slot_allocator_top in rtl/core; no other dependencies.
`ifndef BITMAP_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted.
`define BSA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("bsa check failed");
// Clocked check that also runs during reset.
`define BSA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bsa check failed");
`else
`define BSA_ASSERT(lbl, clk, rstn, prop)
`define BSA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/core/bsa_pkg.sv
// Shared constants and types for the bitmap slot allocator.
// No dependencies.
package bsa_pkg;

    localparam int MAP_WORDS_DEF  = 32;
    localparam int PAGE_SHIFT_DEF = 12;

    localparam int          WORD_BITS   = 32;
    localparam logic [31:0] WINDOW_BASE = 32'h0040_0000;
    localparam logic [31:0] TOP_BIT     = 32'h8000_0000;
    localparam logic [31:0] ALL_FREE    = 32'hffff_ffff;

    typedef logic [1:0] status_t;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_FULL  = 2'd1;
    localparam status_t STATUS_RANGE = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

endpackage

FILE: rtl/core/bsa_map_mem.sv
// Free-map storage: one 32-bit word per entry, single write port,
// single registered read port. Depends on bsa_pkg.
module bsa_map_mem #(
    parameter int DEPTH = bsa_pkg::MAP_WORDS_DEF,
    parameter int AW    = 5
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem_reg [DEPTH];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/bsa_word_op.sv
// Word modify for one transaction: leading free bit search, bit clear/set,
// and slot address composition. Depends on bsa_pkg.
module bsa_word_op #(
    parameter int WW         = 5,
    parameter int PAGE_SHIFT = bsa_pkg::PAGE_SHIFT_DEF
) (
    input  logic          command,
    input  logic [31:0]   word_in,
    input  logic [WW-1:0] word_idx,
    input  logic [4:0]    free_pos,
    output logic [31:0]   word_out,
    output logic [31:0]   slot_addr
);

    logic [4:0]      lead_pos;
    logic [WW+4:0]   slot;
    logic [63:0]     addr_wide;

    // MSB-first numbering: highest set bit is the lowest slot
    always_comb
    begin
        lead_pos = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (word_in[i])
            begin
                lead_pos = 5'(31 - i);
            end
        end
    end

    always_comb
    begin
        if (command == bsa_pkg::CMD_ALLOC)
        begin
            word_out = word_in & ~(bsa_pkg::TOP_BIT >> lead_pos);
        end
        else
        begin
            word_out = word_in | (bsa_pkg::TOP_BIT >> free_pos);
        end
    end

    assign slot      = {word_idx, lead_pos};
    assign addr_wide = (64'(slot) << PAGE_SHIFT) + 64'(bsa_pkg::WINDOW_BASE);
    assign slot_addr = addr_wide[31:0];

endmodule

FILE: rtl/core/bitmap_slot_allocator_top.sv
// Bitmap slot allocator, top level.
// Depends on bsa_pkg, bsa_map_mem, bsa_word_op and the defines header.
//
// Usage:
//  - Input stream (s_axis_*): tuser = command (0 allocate, 1 free),
//    tdata = slot_address (used on free only).
//  - Output stream (m_axis_*): one result transaction per input,
//    tdata = granted_address, tuser = status (0 ok, 1 full, 2 out of window).
//  - Each transaction goes through accept (summary priority encode and
//    map word read issue), then update (word modify, write back, result
//    load). One transaction is in work at a time, so the next allocate
//    always sees the previous update.
//  - Result appears on m_axis right after the update edge.
//  - Reset: every slot is free at once. A fill count marks which map words
//    have been written; words at or above it read as all free, so no
//    clearing pass is needed and the block is ready right after reset.
//  - Receiver stall: the result sits in the output register; the next
//    input is still accepted and read, and its update waits until the
//    output register drains.
`include "bitmap_slot_allocator_top_defines.svh"

module bitmap_slot_allocator_top #(
    parameter int MAP_WORDS  = bsa_pkg::MAP_WORDS_DEF,
    parameter int PAGE_SHIFT = bsa_pkg::PAGE_SHIFT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] slot_address
    input  logic        s_axis_tuser,   // [0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] granted_address
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    localparam int WW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int FW = $clog2(MAP_WORDS + 1);
    localparam logic [31:0] SLOT_COUNT = 32'(MAP_WORDS * bsa_pkg::WORD_BITS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_UPD  = 1'b1;

    logic                  state_reg, state_next;
    logic                  cmd_reg;
    logic                  hit_reg;       // allocate found a word / free in window
    logic [WW-1:0]         word_reg;
    logic [4:0]            pos_reg;
    logic [FW-1:0]         fill_reg;      // words below this have been written
    logic [MAP_WORDS-1:0]  sum_reg;       // 1 = word has a free slot

    logic                  m_valid_reg;
    logic [31:0]           m_data_reg;
    bsa_pkg::status_t      m_user_reg;

    logic                  accept;
    logic                  update;
    logic [WW-1:0]         enc_idx;
    logic                  sum_any;
    logic                  below_win;
    logic [31:0]           win_off;
    logic [31:0]           slot_w;
    logic                  in_range;
    logic [WW-1:0]         acc_word;
    logic                  acc_hit;

    logic [31:0]           rd_data;
    logic [31:0]           word_eff;
    logic [31:0]           word_new;
    logic [31:0]           slot_addr;
    logic                  wr_en;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign update        = (state_reg == ST_UPD) && (!m_valid_reg || m_axis_tready);

    // Lowest word with a free slot
    always_comb
    begin
        enc_idx = '0;
        for (int i = MAP_WORDS - 1; i >= 0; i--)
        begin
            if (sum_reg[i])
            begin
                enc_idx = WW'(i);
            end
        end
    end
    assign sum_any = |sum_reg;

    // Free address decode
    assign below_win = s_axis_tdata < bsa_pkg::WINDOW_BASE;
    assign win_off   = s_axis_tdata - bsa_pkg::WINDOW_BASE;
    assign slot_w    = win_off >> PAGE_SHIFT;
    assign in_range  = !below_win && (slot_w < SLOT_COUNT);

    always_comb
    begin
        if (s_axis_tuser == bsa_pkg::CMD_ALLOC)
        begin
            acc_word = enc_idx;
            acc_hit  = sum_any;
        end
        else
        begin
            acc_word = slot_w[WW+4:5];
            acc_hit  = in_range;
        end
    end

    bsa_map_mem #(
        .DEPTH (MAP_WORDS),
        .AW    (WW)
    ) u_mem (
        .clk   (clk),
        .we    (wr_en),
        .waddr (word_reg),
        .wdata (word_new),
        .re    (accept),
        .raddr (acc_word),
        .rdata (rd_data)
    );

    // Never-written words read as all free
    assign word_eff = (FW'(word_reg) >= fill_reg) ? bsa_pkg::ALL_FREE : rd_data;

    bsa_word_op #(
        .WW         (WW),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_op (
        .command   (cmd_reg),
        .word_in   (word_eff),
        .word_idx  (word_reg),
        .free_pos  (pos_reg),
        .word_out  (word_new),
        .slot_addr (slot_addr)
    );

    assign wr_en = update && hit_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (update)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            sum_reg     <= '1;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                sum_reg[word_reg] <= (word_new != 32'd0);
                if (cmd_reg == bsa_pkg::CMD_ALLOC && FW'(word_reg) == fill_reg)
                begin
                    fill_reg <= fill_reg + FW'(1);
                end
            end
            if (update)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Transaction payload and result registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= s_axis_tuser;
            hit_reg  <= acc_hit;
            word_reg <= acc_word;
            pos_reg  <= slot_w[4:0];
        end
        if (update)
        begin
            if (cmd_reg == bsa_pkg::CMD_ALLOC)
            begin
                m_data_reg <= hit_reg ? slot_addr : 32'd0;
                m_user_reg <= hit_reg ? bsa_pkg::STATUS_OK : bsa_pkg::STATUS_FULL;
            end
            else
            begin
                m_data_reg <= 32'd0;
                m_user_reg <= hit_reg ? bsa_pkg::STATUS_OK : bsa_pkg::STATUS_RANGE;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // Summary must agree with the map word picked for an allocate
    `BSA_ASSERT(a_alloc_word_nonzero, clk, rst_n, (state_reg == ST_UPD && cmd_reg == bsa_pkg::CMD_ALLOC && hit_reg) |-> (word_eff != 32'd0))
    `BSA_ASSERT(a_fill_bounded, clk, rst_n, fill_reg <= FW'(MAP_WORDS))
    `BSA_ASSERT(a_result_after_update, clk, rst_n, $rose(m_axis_tvalid) |-> $past(state_reg == ST_UPD))
    `BSA_ASSERT(a_accept_to_update, clk, rst_n, accept |=> (state_reg == ST_UPD))
    `BSA_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> (state_reg == ST_IDLE))

endmodule
